// ===== hdl/mts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, command codes and melody tables for the tone sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_WRITE  = 3'd1;
	localparam logic [2:0] CMD_PLAY   = 3'd2;
	localparam logic [2:0] CMD_BEEP   = 3'd3;
	localparam logic [2:0] CMD_STOP   = 3'd4;
	localparam logic [2:0] CMD_PAUSE  = 3'd5;
	localparam logic [2:0] CMD_RESUME = 3'd6;

	localparam logic [2:0] MEL_USER    = 3'd0;
	localparam logic [2:0] MEL_UP      = 3'd1;
	localparam logic [2:0] MEL_DOWN    = 3'd2;
	localparam logic [2:0] MEL_TWINKLE = 3'd3;
	localparam logic [2:0] MEL_BB      = 3'd4;
	localparam logic [2:0] MEL_BOOT    = 3'd5;
	localparam logic [2:0] SRC_BEEP    = 3'd6;

	localparam logic [1:0] REG_VOLUME = 2'd0;
	localparam logic [1:0] REG_TEMPO  = 2'd1;
	localparam logic [1:0] REG_RES    = 2'd2;

	localparam int VOL_RST   = 50;
	localparam int TEMPO_RST = 256;
	localparam int RES_RST   = 8;

	localparam logic [18:0] MIN_NOTE_MS = 19'd5;
	localparam logic [18:0] ELAPSED_MAX = 19'h7FFFF;

	typedef struct packed {
		logic [15:0] f;
		logic [15:0] d;
	} tone_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  melody;
		logic [5:0]  note_index;
		logic [15:0] note_freq;
		logic [15:0] note_duration;
		logic [6:0]  seq_length;
		logic        repeat_req;
	} item_t;

	// status after one request; use_fetch: frequency still sits in the fetch register
	typedef struct packed {
		logic        playing;
		logic        paused;
		logic [5:0]  position;
		logic        use_fetch;
		logic [15:0] freq;
	} res_t;

	localparam tone_t ROM_UP [8] = '{
		{16'd262, 16'd200}, {16'd294, 16'd200}, {16'd330, 16'd200}, {16'd349, 16'd200},
		{16'd392, 16'd200}, {16'd440, 16'd200}, {16'd494, 16'd200}, {16'd523, 16'd400}};

	localparam tone_t ROM_DOWN [8] = '{
		{16'd523, 16'd200}, {16'd494, 16'd200}, {16'd440, 16'd200}, {16'd392, 16'd200},
		{16'd349, 16'd200}, {16'd330, 16'd200}, {16'd294, 16'd200}, {16'd262, 16'd400}};

	localparam tone_t ROM_TWINKLE [14] = '{
		{16'd262, 16'd300}, {16'd262, 16'd300}, {16'd392, 16'd300}, {16'd392, 16'd300},
		{16'd440, 16'd300}, {16'd440, 16'd300}, {16'd392, 16'd600}, {16'd349, 16'd300},
		{16'd349, 16'd300}, {16'd330, 16'd300}, {16'd330, 16'd300}, {16'd294, 16'd300},
		{16'd294, 16'd300}, {16'd262, 16'd600}};

	localparam tone_t ROM_BB [5] = '{
		{16'd0, 16'd80}, {16'd780, 16'd120}, {16'd0, 16'd80}, {16'd900, 16'd200},
		{16'd0, 16'd80}};

	localparam tone_t ROM_BOOT [18] = '{
		{16'd523, 16'd60}, {16'd0, 16'd20}, {16'd659, 16'd60}, {16'd0, 16'd20},
		{16'd784, 16'd60}, {16'd0, 16'd60}, {16'd1046, 16'd140}, {16'd0, 16'd40},
		{16'd784, 16'd60}, {16'd659, 16'd60}, {16'd523, 16'd120}, {16'd0, 16'd100},
		{16'd392, 16'd40}, {16'd440, 16'd40}, {16'd466, 16'd40}, {16'd494, 16'd90},
		{16'd0, 16'd60}, {16'd523, 16'd240}};

	function automatic logic [6:0] rom_len(input logic [2:0] src);
		logic [6:0] n;
		case (src)
			MEL_UP:      n = 7'd8;
			MEL_DOWN:    n = 7'd8;
			MEL_TWINKLE: n = 7'd14;
			MEL_BB:      n = 7'd5;
			MEL_BOOT:    n = 7'd18;
			default:     n = 7'd0;
		endcase
		return n;
	endfunction

	function automatic tone_t rom_note(input logic [2:0] src, input logic [5:0] pos);
		tone_t t;
		t = '0;
		case (src)
			MEL_UP:      if (pos < 6'd8)  t = ROM_UP[pos[2:0]];
			MEL_DOWN:    if (pos < 6'd8)  t = ROM_DOWN[pos[2:0]];
			MEL_TWINKLE: if (pos < 6'd14) t = ROM_TWINKLE[pos[3:0]];
			MEL_BB:      if (pos < 6'd5)  t = ROM_BB[pos[2:0]];
			MEL_BOOT:    if (pos < 6'd18) t = ROM_BOOT[pos[4:0]];
			default:     t = '0;
		endcase
		return t;
	endfunction

endpackage

// ===== hdl/mts_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_if
// Valid/ready channels for requests and tone results.
// ----------------------------------------------------------------------------
interface mts_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [2:0]  melody;
	logic [5:0]  note_index;
	logic [15:0] note_freq;
	logic [15:0] note_duration;
	logic [6:0]  seq_length;
	logic        repeat_req;

	modport source (
		output valid, command, melody, note_index, note_freq, note_duration,
		       seq_length, repeat_req,
		input  ready
	);
	modport sink (
		input  valid, command, melody, note_index, note_freq, note_duration,
		       seq_length, repeat_req,
		output ready
	);
endinterface

interface mts_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] tone_freq;
	logic [15:0] duty;
	logic        playing;
	logic        paused;
	logic [5:0]  position;

	modport source (
		output valid, tone_freq, duty, playing, paused, position,
		input  ready
	);
	modport sink (
		input  valid, tone_freq, duty, playing, paused, position,
		output ready
	);
endinterface

// ===== hdl/mts_note_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_note_store
// User note memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module mts_note_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  mts_pkg::tone_t    wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output mts_pkg::tone_t    rdata
);

	mts_pkg::tone_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/mts_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_cfg
// APB register file and PWM duty calculation.
// ----------------------------------------------------------------------------
module mts_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [10:0] tempo,
	output logic [15:0] duty
);

	localparam logic [22:0] PROD_RST = 23'(((1 << mts_pkg::RES_RST) - 1) * mts_pkg::VOL_RST);
	localparam logic [15:0] DUTY_RST = 16'(PROD_RST / 100);
	// x/100 == (x * 10737419) >> 30 for x below 2^23
	localparam logic [23:0] DIV100_MUL = 24'd10737419;

	logic [6:0]  vol_q;
	logic [10:0] tempo_q;
	logic [4:0]  res_q;
	logic [1:0]  idx;
	logic        wr;
	logic [6:0]  vol_nx;
	logic [10:0] tempo_nx;
	logic [4:0]  res_nx;
	logic [15:0] full;
	logic [22:0] prod_q;
	logic        vol_nz_q;
	logic [46:0] quot_full;
	logic [15:0] quot;
	logic [15:0] duty_q;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;

	always_comb begin
		vol_nx   = (pwdata[6:0] > 7'd100) ? 7'd100 : pwdata[6:0];
		tempo_nx = pwdata[10:0];
		if (tempo_nx < 11'd51) tempo_nx = 11'd51;
		if (tempo_nx > 11'd1280) tempo_nx = 11'd1280;
		res_nx = pwdata[4:0];
		if (res_nx < 5'd1) res_nx = 5'd1;
		if (res_nx > 5'd16) res_nx = 5'd16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q   <= 7'(mts_pkg::VOL_RST);
			tempo_q <= 11'(mts_pkg::TEMPO_RST);
			res_q   <= 5'(mts_pkg::RES_RST);
		end else if (wr) begin
			unique case (idx)
				mts_pkg::REG_VOLUME: vol_q   <= vol_nx;
				mts_pkg::REG_TEMPO:  tempo_q <= tempo_nx;
				mts_pkg::REG_RES:    res_q   <= res_nx;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mts_pkg::REG_VOLUME: prdata = 32'(vol_q);
			mts_pkg::REG_TEMPO:  prdata = 32'(tempo_q);
			mts_pkg::REG_RES:    prdata = 32'(res_q);
			default:             prdata = '0;
		endcase
	end

	// full-scale duty times volume is registered, then divided by 100 into the duty register
	assign full      = 16'((17'd1 << res_q) - 17'd1);
	assign quot_full = 47'(prod_q) * 47'(DIV100_MUL);
	assign quot      = quot_full[45:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q   <= PROD_RST;
			vol_nz_q <= 1'b1;
			duty_q   <= DUTY_RST;
		end else begin
			prod_q   <= 23'(full) * 23'(vol_q);
			vol_nz_q <= (vol_q != 7'd0);
			duty_q   <= (quot == 16'd0 && vol_nz_q) ? 16'd1 : quot;
		end
	end

	assign tempo = tempo_q;
	assign duty  = duty_q;

endmodule

// ===== hdl/mts_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_seq
// Playback state, request decode and note fetch.
// ----------------------------------------------------------------------------
module mts_seq #(
	parameter int NOTE_DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            acc,
	input  mts_pkg::item_t  item,
	input  logic [10:0]     tempo,
	output mts_pkg::res_t   res_nx,
	output logic [15:0]     fetch_f
);

	localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

	function automatic logic [18:0] scale_dur(input logic [15:0] d, input logic [10:0] t);
		logic [26:0] p;
		logic [18:0] l;
		p = 27'(d) * 27'(t);
		l = p[26:8];
		if (l < mts_pkg::MIN_NOTE_MS) l = mts_pkg::MIN_NOTE_MS;
		return l;
	endfunction

	logic [2:0]  src_q;
	logic [6:0]  len_q;
	logic [6:0]  pos_q;
	logic        playing_q;
	logic        paused_q;
	logic        loop_q;
	logic [18:0] elapsed_q;
	logic [18:0] sdur_q;
	logic [15:0] cur_q;
	logic        pend_q;
	logic        fsel_user_q;
	mts_pkg::tone_t rom_q;
	mts_pkg::tone_t beep_q;
	mts_pkg::tone_t rd_data;

	logic [15:0] fetch_d;
	logic [15:0] eff_f;
	logic [18:0] eff_sdur;
	logic [18:0] el_inc;
	logic [6:0]  pos_inc;
	logic [6:0]  sl_sat;

	logic [2:0]  n_src;
	logic [6:0]  n_len;
	logic [6:0]  n_pos;
	logic        n_play;
	logic        n_pause;
	logic        n_loop;
	logic [18:0] n_el;
	logic [15:0] n_f;
	logic        try_start;
	logic        start;
	logic        stop;
	mts_pkg::tone_t beep_nx;
	mts_pkg::tone_t rom_nx;

	logic          we;
	logic          re;
	logic [31:0]   waddr_w;
	logic [31:0]   raddr_w;

	// a started note's data lands in rom_q or the store read register in the cycle after the start
	assign fetch_f  = fsel_user_q ? rd_data.f : rom_q.f;
	assign fetch_d  = fsel_user_q ? rd_data.d : rom_q.d;
	assign eff_f    = pend_q ? fetch_f : cur_q;
	assign eff_sdur = pend_q ? scale_dur(fetch_d, tempo) : sdur_q;
	assign el_inc   = (elapsed_q == mts_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 19'd1;
	assign pos_inc  = pos_q + 7'd1;
	assign sl_sat   = (32'(item.seq_length) > NOTE_DEPTH) ? 7'(NOTE_DEPTH) : item.seq_length;

	always_comb begin
		n_src     = src_q;
		n_len     = len_q;
		n_pos     = pos_q;
		n_play    = playing_q;
		n_pause   = paused_q;
		n_loop    = loop_q;
		n_el      = elapsed_q;
		n_f       = eff_f;
		beep_nx   = beep_q;
		try_start = 1'b0;
		stop      = 1'b0;
		we        = 1'b0;
		unique case (item.command)
			mts_pkg::CMD_TICK: begin
				if (playing_q && !paused_q && len_q != 7'd0) begin
					n_el = el_inc;
					if (el_inc >= eff_sdur) begin
						if (pos_inc >= len_q) begin
							if (loop_q) begin
								n_pos     = 7'd0;
								try_start = 1'b1;
							end else begin
								stop = 1'b1;
							end
						end else begin
							n_pos     = pos_inc;
							try_start = 1'b1;
						end
					end
				end
			end
			mts_pkg::CMD_WRITE: begin
				we = (32'(item.note_index) < NOTE_DEPTH);
			end
			mts_pkg::CMD_PLAY: begin
				if (item.melody == mts_pkg::MEL_USER) begin
					n_src = mts_pkg::MEL_USER;
					n_len = sl_sat;
				end else if (item.melody <= mts_pkg::MEL_BOOT) begin
					n_src = item.melody;
					n_len = mts_pkg::rom_len(item.melody);
				end
				n_loop    = item.repeat_req;
				n_pos     = 7'd0;
				n_pause   = 1'b0;
				n_play    = 1'b1;
				try_start = 1'b1;
			end
			mts_pkg::CMD_BEEP: begin
				beep_nx   = {item.note_freq, item.note_duration};
				n_src     = mts_pkg::SRC_BEEP;
				n_len     = 7'd1;
				n_loop    = 1'b0;
				n_pos     = 7'd0;
				n_pause   = 1'b0;
				n_play    = 1'b1;
				try_start = 1'b1;
			end
			mts_pkg::CMD_STOP: begin
				stop = 1'b1;
			end
			mts_pkg::CMD_PAUSE: begin
				if (playing_q) begin
					n_pause = 1'b1;
					n_f     = 16'd0;
				end
			end
			mts_pkg::CMD_RESUME: begin
				if (playing_q && paused_q) begin
					n_pause   = 1'b0;
					n_el      = 19'd0;
					try_start = 1'b1;
				end
			end
			default: ;
		endcase

		if (stop) begin
			n_play  = 1'b0;
			n_pause = 1'b0;
			n_pos   = 7'd0;
			n_len   = 7'd0;
			n_f     = 16'd0;
		end

		start = 1'b0;
		if (try_start) begin
			if (n_len == 7'd0 || n_pos >= n_len) begin
				n_f = 16'd0;
			end else begin
				start = 1'b1;
				n_el  = 19'd0;
			end
		end

		rom_nx = (n_src == mts_pkg::SRC_BEEP) ? beep_nx : mts_pkg::rom_note(n_src, n_pos[5:0]);
		re     = acc && start && (n_src == mts_pkg::MEL_USER);

		res_nx.playing   = n_play;
		res_nx.paused    = n_pause;
		res_nx.position  = n_pos[5:0];
		res_nx.use_fetch = start;
		res_nx.freq      = (n_play && !n_pause) ? n_f : 16'd0;
	end

	assign waddr_w = 32'(item.note_index);
	assign raddr_w = 32'(n_pos);

	mts_note_store #(
		.DEPTH (NOTE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (acc && we),
		.waddr (waddr_w[AW-1:0]),
		.wdata ({item.note_freq, item.note_duration}),
		.re    (re),
		.raddr (raddr_w[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q     <= mts_pkg::MEL_USER;
			len_q     <= '0;
			pos_q     <= '0;
			playing_q <= 1'b0;
			paused_q  <= 1'b0;
			loop_q    <= 1'b0;
			elapsed_q <= '0;
			sdur_q    <= '0;
			cur_q     <= '0;
			pend_q    <= 1'b0;
		end else if (acc) begin
			src_q     <= n_src;
			len_q     <= n_len;
			pos_q     <= n_pos;
			playing_q <= n_play;
			paused_q  <= n_pause;
			loop_q    <= n_loop;
			elapsed_q <= n_el;
			pend_q    <= start;
			if (!start) begin
				cur_q  <= n_f;
				sdur_q <= eff_sdur;
			end
		end else if (pend_q) begin
			// fold the fetched note into the state registers
			cur_q  <= eff_f;
			sdur_q <= eff_sdur;
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			beep_q <= beep_nx;
			if (start) begin
				fsel_user_q <= (n_src == mts_pkg::MEL_USER);
				rom_q       <= rom_nx;
			end
		end
	end

endmodule

// ===== hdl/melody_tone_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melody_tone_sequencer_core
// Note sequencer for a PWM buzzer: ROM melodies, user note store and beeps.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - request channel (valid/ready): tick, write note, play, beep, stop,
//          pause, resume. Every request yields exactly one result.
//   tone - result channel (valid/ready): frequency, duty, playing, paused
//          and position after the request.
//   APB  - volume, tempo and PWM resolution; write only while idle.
// Pipeline: each result passes the decode/state register, then the
//   output register.
// Throughput: one request per cycle unless the output stalls; the whole state update is one pass.
//   A started note's data arrives from the ROM register or the note store
//   read port in the next cycle and is folded into the state then.
// Reset: playback stopped, registers at volume 50, tempo 256, 8 bits. The
//   note store is not cleared; entries read before being written are junk.
// Stall: with the output held, one more request is taken into the first
//   stage, after which ready drops until the output drains.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_core #(
	parameter int NOTE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	mts_in_if.sink      cmd,
	mts_out_if.source   tone
);

	logic [10:0]    tempo;
	logic [15:0]    duty;
	mts_pkg::item_t item;
	mts_pkg::res_t  res_nx;
	logic [15:0]    fetch_f;
	logic           acc;
	logic           adv;

	logic           s1_valid_q;
	mts_pkg::res_t  s1_q;
	logic           s2_valid_q;
	logic [15:0]    freq_s2;
	logic           playing_s2;
	logic           paused_s2;
	logic [5:0]     pos_s2;

	mts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tempo   (tempo),
		.duty    (duty)
	);

	assign item.command       = cmd.command;
	assign item.melody        = cmd.melody;
	assign item.note_index    = cmd.note_index;
	assign item.note_freq     = cmd.note_freq;
	assign item.note_duration = cmd.note_duration;
	assign item.seq_length    = cmd.seq_length;
	assign item.repeat_req    = cmd.repeat_req;

	assign adv       = s1_valid_q && (!s2_valid_q || tone.ready);
	assign cmd.ready = !s1_valid_q || adv;
	assign acc       = cmd.valid && cmd.ready;

	mts_seq #(
		.NOTE_DEPTH (NOTE_DEPTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.item    (item),
		.tempo   (tempo),
		.res_nx  (res_nx),
		.fetch_f (fetch_f)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				s2_valid_q <= 1'b1;
			end else if (tone.ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_q <= res_nx;
		end
		if (adv) begin
			freq_s2    <= s1_q.use_fetch ? fetch_f : s1_q.freq;
			playing_s2 <= s1_q.playing;
			paused_s2  <= s1_q.paused;
			pos_s2     <= s1_q.position;
		end
	end

	assign tone.valid     = s2_valid_q;
	assign tone.tone_freq = freq_s2;
	assign tone.duty      = (freq_s2 != 16'd0) ? duty : 16'd0;
	assign tone.playing   = playing_s2;
	assign tone.paused    = paused_s2;
	assign tone.position  = pos_s2;

	a_sound_when_playing: assert property (@(posedge clk) disable iff (!arst_n)
		(tone.valid && tone.tone_freq != 16'd0) |-> (tone.playing && !tone.paused))
		else $error("tone while not playing");

	a_pause_needs_play: assert property (@(posedge clk) disable iff (!arst_n)
		(tone.valid && tone.paused) |-> tone.playing)
		else $error("paused while stopped");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!s2_valid_q |-> cmd.ready)
		else $error("request stalled with empty output");

	a_fetch_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_q.use_fetch && !adv) |=> $stable(fetch_f))
		else $error("fetched note lost while result waits");

endmodule
